[hdl/ukdt_pkg.sv]
`timescale 1ns / 1ps

package ukdt_pkg;

    localparam int KEY_W    = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_CREATED  = 3'd0,
        RES_EXISTS   = 3'd1,
        RES_DELETED  = 3'd2,
        RES_NOTFOUND = 3'd3,
        RES_FOUND    = 3'd4,
        RES_FULL     = 3'd5,
        RES_LISTED   = 3'd6,
        RES_EMPTY    = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_FINISH,
        S_LIST_RD,
        S_LIST_OUT
    } state_t;

endpackage

[hdl/ukdt_ram.sv]
`timescale 1ns / 1ps

module ukdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/unique_key_directory_table_top.sv]
`timescale 1ns / 1ps
// Directory of up to ENTRIES unique 64-bit keys (names of up to 8 packed chars).
// Input channel: in_valid / in_stall carrying op and key. One command at a time:
//   in_stall is high from the accepting edge until the command has handed its
//   last result to the output register.
// Output channel: out_valid / out_stall carrying status, entry_key, last.
//   Results sit in an output register; while the receiver stalls, the register
//   holds and the sequencer waits before loading the next result.
// Operation steps (one RAM port pair):
//   search / create / failed delete: one entry read per cycle, compare in the
//     cycle after the read, then the result.
//   delete of a found key: scan until it is found, then the tail shift moving
//     one entry per cycle (read i+1, write i).
//   list: each entry is read, then loaded into the output register when the
//     receiver is free; an empty directory gives one "empty" result.
// A new command is taken in the cycle after the last result is loaded, even
// if that result is still waiting on the receiver.
// Reset clears the entry count; key storage has no reset and needs none,
// since only entries below the count are ever read.
module unique_key_directory_table_top
    import ukdt_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [KEY_W-1:0]    key,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [KEY_W-1:0]    entry_key,
    output logic                last
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               pend_reg, pend_next;       // RAM data is valid for pend_idx
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    status_t            res_reg, res_next;         // single result for S_FINISH

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [KEY_W-1:0]   entry_key_reg, entry_key_next;
    logic               last_reg, last_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [KEY_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [KEY_W-1:0]   mem_rdata;

    logic               accept;
    logic               out_free;
    logic               hit;
    logic               scan_done;
    logic               more;
    logic               list_last;

    ukdt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    // compare runs in the cycle after the read
    assign hit       = pend_reg && (mem_rdata == key_reg);
    assign more      = (rd_idx_reg < count_reg);
    assign scan_done = !pend_reg && !more;
    assign list_last = ((rd_idx_reg + CNT_W'(1)) == count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(op) == OP_LIST)
                    begin
                        state_next = (count_reg == '0) ? S_FINISH : S_LIST_RD;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    state_next = (op_reg == OP_DELETE) ? S_SHIFT : S_FINISH;
                end
                else if (scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                if (scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (out_free)
                begin
                    state_next = list_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        entry_key_next = entry_key_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata      = key_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_t'(op);
                    key_next    = key;
                    rd_idx_next = '0;
                    res_next    = RES_EMPTY;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    case (op_reg)
                        OP_CREATE: res_next = RES_EXISTS;
                        OP_SEARCH: res_next = RES_FOUND;
                        default:   res_next = RES_DELETED;
                    endcase
                    // tail shift starts at the entry after the match
                    rd_idx_next = CNT_W'(pend_idx_reg) + CNT_W'(1);
                end
                else if (scan_done)
                begin
                    if (op_reg == OP_CREATE)
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            res_next = RES_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            res_next   = RES_CREATED;
                        end
                    end
                    else
                    begin
                        res_next = RES_NOTFOUND;
                    end
                end
                else if (more)
                begin
                    mem_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_idx_reg - IDX_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (more)
                begin
                    mem_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                    entry_key_next = '0;
                    last_next      = 1'b1;
                end
            end
            S_LIST_RD:
            begin
                mem_re = 1'b1;
            end
            S_LIST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = RES_LISTED;
                    entry_key_next = mem_rdata;
                    last_next      = list_last;
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        rd_idx_reg    <= rd_idx_next;
        pend_idx_reg  <= pend_idx_next;
        res_reg       <= res_next;
        status_reg    <= status_next;
        entry_key_reg <= entry_key_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign entry_key = entry_key_reg;
    assign last      = last_reg;

endmodule

[tb/sv/ukdt_directory_checker.sv]
`timescale 1ns / 1ps

module ukdt_directory_checker
    import ukdt_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [KEY_W-1:0]    key,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [KEY_W-1:0]    entry_key,
    input  logic                last,
    output int                  fail_count,
    output int                  pending_results
);

    typedef struct {
        status_t          res_status;
        logic [KEY_W-1:0] res_key;
        logic             res_last;
    } dir_reply_t;

    logic [KEY_W-1:0] dir_names[$];     // shadow of the directory, in stored order
    dir_reply_t       replies_due[$];   // predicted results not yet seen
    int               fail_tally = 0;
    int               due_tally  = 0;

    assign fail_count      = fail_tally;
    assign pending_results = due_tally;

    function automatic int name_index(logic [KEY_W-1:0] name);
        foreach (dir_names[i])
        begin
            if (dir_names[i] == name)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void push_reply(status_t st, logic [KEY_W-1:0] k, logic lst);
        dir_reply_t r;
        r.res_status = st;
        r.res_key    = k;
        r.res_last   = lst;
        replies_due.push_back(r);
    endfunction

    // Updates the shadow directory and queues the replies of one command.
    function automatic void run_directory_command(op_t cmd, logic [KEY_W-1:0] name);
        int idx;
        idx = name_index(name);
        case (cmd)
            OP_CREATE:
            begin
                if (idx >= 0)
                begin
                    push_reply(RES_EXISTS, '0, 1'b1);
                end
                else if (dir_names.size() >= ENTRIES)
                begin
                    push_reply(RES_FULL, '0, 1'b1);
                end
                else
                begin
                    dir_names.push_back(name);
                    push_reply(RES_CREATED, '0, 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (idx < 0)
                begin
                    push_reply(RES_NOTFOUND, '0, 1'b1);
                end
                else
                begin
                    dir_names.delete(idx);
                    push_reply(RES_DELETED, '0, 1'b1);
                end
            end
            OP_SEARCH:
            begin
                push_reply((idx >= 0) ? RES_FOUND : RES_NOTFOUND, '0, 1'b1);
            end
            default:
            begin
                if (dir_names.size() == 0)
                begin
                    push_reply(RES_EMPTY, '0, 1'b1);
                end
                else
                begin
                    foreach (dir_names[i])
                    begin
                        push_reply(RES_LISTED, dir_names[i], i == dir_names.size() - 1);
                    end
                end
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        dir_reply_t due;
        if (rst_n)
        begin
            // result first: it belongs to an older command than any item taken now
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    fail_tally++;
                    if (fail_tally <= 10)
                    begin
                        $display("%0t: unexpected result: status %0d key %h last %0b",
                                 $time, status, entry_key, last);
                    end
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (status !== due.res_status || entry_key !== due.res_key ||
                        last !== due.res_last)
                    begin
                        fail_tally++;
                        if (fail_tally <= 10)
                        begin
                            $display({"%0t: mismatch: status exp %0d got %0d, ",
                                      "key exp %h got %h, last exp %0b got %0b"},
                                     $time, due.res_status, status, due.res_key,
                                     entry_key, due.res_last, last);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                run_directory_command(op_t'(op), key);
            end
        end
        due_tally <= replies_due.size();
    end

endmodule

[tb/sv/unique_key_directory_table_top_tb.sv]
`timescale 1ns / 1ps

module unique_key_directory_table_top_tb;
    import ukdt_pkg::*;

    localparam int ENTRIES     = 32;
    localparam int POOL        = 48;          // more names than slots, so the table fills
    localparam int LONG_HOLD   = 300;         // receiver hold-off, in cycles
    localparam int TAIL_CYCLES = 4 * ENTRIES; // drain margin after the last reply

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             out_stall = 1'b0;
    op_t              cmd_op    = OP_CREATE;
    logic [KEY_W-1:0] cmd_key   = '0;

    logic                in_stall;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    entry_key;
    logic                last;

    int fail_count;
    int pending_results;

    // Pacing knobs, changed per phase by the stimulus process.
    int gap_pct   = 0;  // chance of a sender gap after each item, in percent
    int stall_pct = 0;  // chance per cycle that the receiver starts a stall burst
    bit hold_go   = 1'b0;

    logic [KEY_W-1:0] name_pool[POOL];

    unique_key_directory_table_top #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (cmd_op),
        .key       (cmd_key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .entry_key (entry_key),
        .last      (last)
    );

    ukdt_directory_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (cmd_op),
        .key             (cmd_key),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .entry_key       (entry_key),
        .last            (last),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin : clock_gen
        forever #1 clk = ~clk;
    end

    // Offer one command and hold it until the block takes it. The payload stays
    // put while stalled; after acceptance a random gap may follow.
    task automatic send_cmd(op_t cmd, logic [KEY_W-1:0] name);
        cmd_op   <= cmd;
        cmd_key  <= name;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    function automatic op_t pick_op(int create_w, int delete_w, int search_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < create_w) return OP_CREATE;
        if (r < create_w + delete_w) return OP_DELETE;
        if (r < create_w + delete_w + search_w) return OP_SEARCH;
        return OP_LIST;
    endfunction

    // Creates only draw from the pool and the two extreme names, so every stored
    // name can later be hit by a delete. Other commands also get random noise.
    function automatic logic [KEY_W-1:0] pick_name(bit for_create);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        if (!for_create && r < 30) return {$urandom, $urandom};
        return name_pool[$urandom_range(0, POOL - 1)];
    endfunction

    task automatic run_phase(int items, int create_w, int delete_w, int search_w,
                             int gp, int sp);
        op_t cmd;
        gap_pct   = gp;
        stall_pct = sp;
        repeat (items) begin
            cmd = pick_op(create_w, delete_w, search_w);
            send_cmd(cmd, pick_name(cmd == OP_CREATE));
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : rx_pacing
        forever begin
            @(posedge clk);
            if (hold_go) begin
                hold_go = 1'b0;
                out_stall <= 1'b1;
                for (int n = 0; n < LONG_HOLD; n++) begin
                    @(posedge clk);
                end
                out_stall <= 1'b0;
            end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        foreach (name_pool[i]) begin
            name_pool[i] = {$urandom, $urandom};
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, zero and all-ones names, duplicates, misses,
        // deletes at the head, middle and tail of the table, list before and after.
        gap_pct   = 20;
        stall_pct = 20;
        send_cmd(OP_LIST,   '0);
        send_cmd(OP_SEARCH, '0);
        send_cmd(OP_DELETE, '1);
        send_cmd(OP_CREATE, '0);
        send_cmd(OP_CREATE, '0);
        send_cmd(OP_CREATE, '1);
        send_cmd(OP_CREATE, 64'h5555_5555_5555_5555);
        send_cmd(OP_CREATE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_cmd(OP_CREATE, 64'h6669_6c65_2e74_7874);   // "file.txt"
        send_cmd(OP_SEARCH, '1);
        send_cmd(OP_SEARCH, 64'h1);
        send_cmd(OP_LIST,   '1);
        send_cmd(OP_DELETE, '0);
        send_cmd(OP_DELETE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_cmd(OP_DELETE, 64'h6669_6c65_2e74_7874);
        send_cmd(OP_DELETE, '0);
        send_cmd(OP_LIST,   '0);
        send_cmd(OP_DELETE, '1);
        send_cmd(OP_DELETE, 64'h5555_5555_5555_5555);
        send_cmd(OP_LIST,   '0);

        // Fill past capacity: the last creates hit a full table, then a duplicate
        // on a full table must still report that it exists.
        gap_pct   = 0;
        stall_pct = 10;
        for (int i = 0; i < ENTRIES + 4; i++) begin
            send_cmd(OP_CREATE, name_pool[i]);
        end
        send_cmd(OP_CREATE, name_pool[3]);

        // Long receiver hold-off with a full list in flight; the sender keeps
        // offering so the block backs up and stalls its input.
        hold_go = 1'b1;
        send_cmd(OP_LIST,   '0);
        send_cmd(OP_SEARCH, name_pool[ENTRIES - 1]);
        send_cmd(OP_LIST,   '0);
        send_cmd(OP_DELETE, name_pool[0]);
        send_cmd(OP_DELETE, name_pool[ENTRIES - 1]);
        send_cmd(OP_DELETE, name_pool[ENTRIES / 2]);
        send_cmd(OP_SEARCH, name_pool[ENTRIES / 2]);
        send_cmd(OP_LIST,   '0);

        // Random phases: bias the mix to sweep the fill level up and down.
        run_phase(70, 55, 15, 20, 20, 20);
        run_phase(70, 15, 55, 20,  0, 30);
        run_phase(70, 35, 30, 20, 25,  0);
        run_phase(70, 60, 10, 15, 10, 10);
        run_phase(70, 20, 50, 15, 30, 30);
        // last stretch runs back to back on both sides
        run_phase(70, 35, 30, 20,  0,  0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
